// ----- rtl/mi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mi_pkg: shared types for the modular inverse unit
// Controller states, datapath commands and datapath status.
// ----------------------------------------------------------------------------
package mi_pkg;

   localparam int unsigned WIDTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DIVIDE,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic load;    // take a new operand pair
      logic start;   // begin one euclid iteration
      logic step;    // one division bit and one multiply bit
      logic update;  // rotate the remainder and coefficient pairs
      logic finish;  // write the result register
   } cmd_type;

   typedef struct packed {
      logic b_zero;  // divisor is zero, euclid loop has ended
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/mi_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mi_datapath: euclid datapath
// Restoring divider producing one quotient bit per cycle, fed straight into a
// double-and-add modular multiplier, plus the coefficient update and the
// result register.
// ----------------------------------------------------------------------------
module mi_datapath #(
   parameter int unsigned WIDTH = mi_pkg::WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire mi_pkg::cmd_type    cmd,
   input  wire logic [WIDTH-1:0]   modulus,
   input  wire logic [WIDTH-1:0]   value,
   output mi_pkg::status_type      status,
   output logic [WIDTH-1:0]        inverse,
   output logic [WIDTH-1:0]        common_divisor
);

   localparam int unsigned EXT_W = WIDTH + 2;

   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] t1_ff, t1_in;
   logic [WIDTH-1:0] t2_ff, t2_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] inv_ff, inv_in;
   logic [WIDTH-1:0] gcd_ff, gcd_in;

   logic [WIDTH:0]   shifted;
   logic             qbit;
   logic [EXT_W-1:0] m_ext, m2_ext, dbl, dbl_add;
   logic [WIDTH-1:0] acc_next;

   // one restoring division step
   always_comb begin
      shifted = {rem_ff, dvd_ff[WIDTH-1]};
      qbit    = (shifted >= {1'b0, b_ff});
   end

   // (2*acc + qbit*t2) mod m, all candidates formed side by side
   always_comb begin
      m_ext   = EXT_W'(m_ff);
      m2_ext  = EXT_W'({m_ff, 1'b0});
      dbl     = EXT_W'({acc_ff, 1'b0});
      dbl_add = dbl + EXT_W'(t2_ff);
      if (qbit) begin
         if (dbl_add >= m2_ext) begin
            acc_next = WIDTH'(dbl_add - m2_ext);
         end else if (dbl_add >= m_ext) begin
            acc_next = WIDTH'(dbl_add - m_ext);
         end else begin
            acc_next = WIDTH'(dbl_add);
         end
      end else begin
         if (dbl >= m_ext) begin
            acc_next = WIDTH'(dbl - m_ext);
         end else begin
            acc_next = WIDTH'(dbl);
         end
      end
   end

   always_comb begin
      m_in   = m_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      t1_in  = t1_ff;
      t2_in  = t2_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      acc_in = acc_ff;
      inv_in = inv_ff;
      gcd_in = gcd_ff;
      if (cmd.load) begin
         m_in  = modulus;
         t1_in = '0;
         t2_in = WIDTH'(modulus > WIDTH'(1));
         // a zero modulus ends at once with gcd equal to the value
         if (modulus == '0) begin
            a_in = value;
            b_in = '0;
         end else begin
            a_in = modulus;
            b_in = value;
         end
      end
      if (cmd.start) begin
         rem_in = '0;
         dvd_in = a_ff;
         acc_in = '0;
      end
      if (cmd.step) begin
         rem_in = qbit ? WIDTH'(shifted - {1'b0, b_ff}) : WIDTH'(shifted);
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         acc_in = acc_next;
      end
      if (cmd.update) begin
         a_in  = b_ff;
         b_in  = rem_ff;
         t1_in = t2_ff;
         // (t1 - q*t2) mod m, wraps back into range
         t2_in = t1_ff - acc_ff + ((t1_ff < acc_ff) ? m_ff : '0);
      end
      if (cmd.finish) begin
         inv_in = (m_ff > WIDTH'(1)) ? t1_ff : '0;
         gcd_in = a_ff;
      end
   end

   always_ff @(posedge clock) begin
      m_ff   <= m_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      acc_ff <= acc_in;
      inv_ff <= inv_in;
      gcd_ff <= gcd_in;
   end

   assign status.b_zero  = (b_ff == '0);
   assign inverse        = inv_ff;
   assign common_divisor = gcd_ff;

endmodule
`default_nettype wire

// ----- rtl/mi_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mi_ctrl: euclid sequencer
// Walks each iteration through check, divide and update, counts the division
// bits and owns both handshakes.
// ----------------------------------------------------------------------------
module mi_ctrl #(
   parameter int unsigned WIDTH = mi_pkg::WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire mi_pkg::status_type status,
   output mi_pkg::cmd_type         cmd
);

   localparam int unsigned CNT_W = $clog2(WIDTH);

   mi_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              cnt_last;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cnt_last = (cnt_ff == CNT_W'(WIDTH - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mi_pkg::S_IDLE: begin
            if (req_tvalid) state_in = mi_pkg::S_CHECK;
         end
         mi_pkg::S_CHECK: begin
            if (!status.b_zero) begin
               state_in = mi_pkg::S_DIVIDE;
            end else if (out_free) begin
               state_in = mi_pkg::S_IDLE;
            end
         end
         mi_pkg::S_DIVIDE: begin
            if (cnt_last) state_in = mi_pkg::S_UPDATE;
         end
         mi_pkg::S_UPDATE: begin
            state_in = mi_pkg::S_CHECK;
         end
         default: state_in = mi_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      cnt_in     = cnt_ff;
      unique case (state_ff)
         mi_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         mi_pkg::S_CHECK: begin
            cmd.start  = !status.b_zero;
            cmd.finish = status.b_zero && out_free;
            cnt_in     = '0;
         end
         mi_pkg::S_DIVIDE: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
         end
         mi_pkg::S_UPDATE: begin
            cmd.update = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mi_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // an accepted pair always goes to the loop test next
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == mi_pkg::S_CHECK))
      else $error("accepted pair did not start the loop");

   // the result register is never overwritten while still held
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");

   // every division runs a full word of steps from a cleared count
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == mi_pkg::S_DIVIDE && cnt_ff == '0))
      else $error("division did not start from a cleared count");

   // update only follows the last division step
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> ($past(state_ff) == mi_pkg::S_DIVIDE && $past(cnt_last)))
      else $error("update without a complete division");

endmodule
`default_nettype wire

// ----- rtl/modular_inverse_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse_unit: extended euclid modular inverse
// Takes a modulus and a value on the req stream, returns the inverse reduced
// into 0 .. modulus-1 and the gcd on the rsp stream.
//
// One operand pair per req transfer, one result per rsp transfer, in order.
// A pair is taken only while the unit is idle; req_tready is high then.
// Each euclid iteration passes through the check state, WIDTH steps on the
// restoring divider (the multiply-mod-m of the quotient rides along, one
// quotient bit per cycle), and the update state. After the last iteration
// the check state writes the result register and the unit returns to idle,
// where the next pair can be taken; at WIDTH = 32 there are at most 47
// iterations per item.
// The result sits in an output register, so the next pair is accepted as
// soon as the result is written, even while rsp_tready is low. If the last
// result is still held when a new one is ready, the unit waits in its check
// state until the rsp transfer happens.
// Reset clears the sequencer and the result valid flag; nothing else.
// A value of zero returns inverse 0 and gcd equal to the modulus.
// ----------------------------------------------------------------------------
module modular_inverse_unit #(
   parameter int unsigned WIDTH = mi_pkg::WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // modulus, value
   input  wire logic [((2*WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // inverse, common_divisor
   output logic [((2*WIDTH+7)/8)*8-1:0]           rsp_tdata
);

   localparam int unsigned DATA_W = ((2 * WIDTH + 7) / 8) * 8;

   mi_pkg::cmd_type    cmd;
   mi_pkg::status_type status;
   logic [WIDTH-1:0]   inverse;
   logic [WIDTH-1:0]   common_divisor;

   mi_ctrl #(
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mi_datapath #(
      .WIDTH(WIDTH)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .modulus        (req_tdata[WIDTH-1:0]),
      .value          (req_tdata[2*WIDTH-1:WIDTH]),
      .status         (status),
      .inverse        (inverse),
      .common_divisor (common_divisor)
   );

   assign rsp_tdata = DATA_W'({common_divisor, inverse});

endmodule
`default_nettype wire
